FILE: hdl/ed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_pkg
// shared types and constants of the edit distance engine
// ----------------------------------------------------------------------------
package ed_pkg;

   localparam int SYM_W  = 8;
   localparam int OP_W   = 2;
   localparam int DIST_W = 7;

   localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

   localparam logic [DIST_W-1:0] OVERFLOW_DISTANCE = 7'd100;

   // register index carried in csr address bit 2
   localparam logic REG_TRANSPOSITION = 1'b0;

   // one row of the wavefront travelling from a cell to its right neighbour
   typedef struct packed {
      logic              valid;
      logic              first;  // row one, no row two back yet
      logic              last;   // last row of the first string
      logic [SYM_W-1:0]  sym;    // symbol of this row
      logic [SYM_W-1:0]  psym;   // symbol of the row above
      logic [DIST_W-1:0] val;    // score of this row at the sender's column
      logic [DIST_W-1:0] diag;   // score of the row above, one column left
   } cell_link_type;

endpackage

FILE: hdl/ed_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_cell
// one column of the edit distance wavefront
// ----------------------------------------------------------------------------
module ed_cell import ed_pkg::*; #(
   parameter int COL = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tr_en,
   input  logic               init,
   input  logic               load_en,
   input  logic [SYM_W-1:0]   load_sym,
   input  logic [SYM_W-1:0]   prev_b,
   output logic [SYM_W-1:0]   b,
   input  cell_link_type      link_w,
   output cell_link_type      link_e
);

   localparam logic [DIST_W-1:0] COL_VAL    = DIST_W'(COL);
   localparam logic [DIST_W-1:0] COL_M1_VAL = DIST_W'(COL - 1);
   localparam logic              HAS_LEFT2  = (COL > 1);

   logic [SYM_W-1:0]  b_ff;
   cell_link_type     link_ff, link_in;
   logic [DIST_W-1:0] left_prev_ff;   // score one row up, one column left
   logic [DIST_W-1:0] twoback_ff;     // score two rows up, two columns left

   logic [DIST_W-1:0] cost, up1, left1, diag_c, tw1, best;
   logic              swap_ok;

   always_comb begin
      cost    = (link_w.sym != b_ff) ? DIST_W'(1) : DIST_W'(0);
      up1     = link_ff.val + DIST_W'(1);
      left1   = link_w.val + DIST_W'(1);
      diag_c  = left_prev_ff + cost;
      tw1     = twoback_ff + DIST_W'(1);
      swap_ok = tr_en && HAS_LEFT2 && !link_w.first
                && (link_w.sym == prev_b) && (link_w.psym == b_ff);
      best = (up1 < left1) ? up1 : left1;
      if (diag_c < best) best = diag_c;
      if (swap_ok && (tw1 < best)) best = tw1;

      link_in = link_ff;
      // a new compute flushes any rows of the previous one still in the chain
      link_in.valid = link_w.valid && !init && !reset;
      if (init) begin
         link_in.val = COL_VAL;
      end else if (link_w.valid) begin
         link_in.first = link_w.first;
         link_in.last  = link_w.last;
         link_in.sym   = link_w.sym;
         link_in.psym  = link_w.psym;
         link_in.val   = best;
         link_in.diag  = left_prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) b_ff <= load_sym;
      link_ff <= link_in;
      if (init) begin
         left_prev_ff <= COL_M1_VAL;
      end else if (link_w.valid) begin
         left_prev_ff <= link_w.val;
         twoback_ff   <= link_w.diag;
      end
   end

   assign b      = b_ff;
   assign link_e = link_ff;

endmodule

FILE: hdl/ed_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_array
// chain of column cells holding the second string, with result pick-off
// ----------------------------------------------------------------------------
module ed_array import ed_pkg::*; #(
   parameter int MAX_LEN = 32,
   parameter int CNT_W   = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tr_en,
   input  logic               init,
   input  logic               load_en,
   input  logic [CNT_W-1:0]   load_idx,
   input  logic [SYM_W-1:0]   load_sym,
   input  logic [CNT_W-1:0]   sel_len,
   input  cell_link_type      feed,
   output logic               done,
   output logic [DIST_W-1:0]  done_val
);

   cell_link_type    link [MAX_LEN+1];
   logic [SYM_W-1:0] b_bus [MAX_LEN];
   logic [MAX_LEN-1:0] hit;

   assign link[0] = feed;

   for (genvar c = 0; c < MAX_LEN; c++) begin : g_cell
      logic [SYM_W-1:0] prev_b;
      if (c == 0) begin : g_edge
         assign prev_b = '0;
      end else begin : g_inner
         assign prev_b = b_bus[c-1];
      end

      ed_cell #(.COL(c + 1)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tr_en    (tr_en),
         .init     (init),
         .load_en  (load_en && (load_idx == CNT_W'(c))),
         .load_sym (load_sym),
         .prev_b   (prev_b),
         .b        (b_bus[c]),
         .link_w   (link[c]),
         .link_e   (link[c+1])
      );

      assign hit[c] = (sel_len == CNT_W'(c + 1)) && link[c+1].valid && link[c+1].last;
   end

   // and-or pick of the column that matches the second string's length
   always_comb begin
      done     = 1'b0;
      done_val = '0;
      for (int c = 0; c < MAX_LEN; c++) begin
         done     = done | hit[c];
         done_val = done_val | (link[c+1].val & {DIST_W{hit[c]}});
      end
   end

endmodule

FILE: hdl/edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine
// restricted damerau-levenshtein distance between two loaded byte strings
// ----------------------------------------------------------------------------
// Items on the req stream either append a byte to the first or second string
// or ask for the distance. An append gives no result. A compute gives one
// result item and clears both strings. The distance comes from a row of
// MAX_LEN column cells, one per symbol of the second string; the first string
// is fed in one symbol per cycle and each row ripples through the chain as a
// diagonal wavefront, so the run time of a compute is set by the length of
// that wavefront. A compute with an empty string or an overflowed string
// (more than MAX_LEN appends) bypasses the chain and goes straight to the
// result wait state (100 on overflow). The block takes one item at a time:
// req_tready is low from a compute until its result has moved into the rsp
// output register. Transposition counting is switched by the register at csr
// address 0 (reset 1).
// ----------------------------------------------------------------------------
module edit_distance_engine import ed_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req item: [1:0] operation, [9:2] symbol, [15:10] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp item: [6:0] distance, [7] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic              tr_en_ff;
   logic [CNT_W-1:0]  a_cnt_ff, b_cnt_ff;
   logic              a_ovf_ff, b_ovf_ff;
   logic [SYM_W-1:0]  a_mem_ff [MAX_LEN];
   logic [CNT_W-1:0]  la_ff, lb_ff;
   logic [CNT_W-1:0]  rd_ff;
   logic [SYM_W-1:0]  prev_a_ff;
   cell_link_type     feed_ff;
   logic [DIST_W-1:0] res_ff;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_data_ff;

   logic [OP_W-1:0]   req_op;
   logic [SYM_W-1:0]  req_sym;
   logic              acc, app_a, app_b, do_comp, start_run;
   logic              done;
   logic [DIST_W-1:0] done_val;
   logic              rsp_load;
   logic              csr_wr;
   logic [SYM_W-1:0]  a_sym;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TRANSPOSITION) ? {31'd0, tr_en_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_en_ff <= 1'b1;
      end else if (csr_wr && (csr_paddr[2] == REG_TRANSPOSITION)) begin
         tr_en_ff <= csr_pwdata[0];
      end
   end

   // ---------------- item decode ----------------
   assign req_op  = req_tdata[1:0];
   assign req_sym = req_tdata[9:2];
   assign req_tready = (state_ff == ST_IDLE);
   assign acc     = req_tvalid && req_tready;
   assign app_a   = acc && (req_op == OP_APPEND_FIRST);
   assign app_b   = acc && (req_op == OP_APPEND_SECOND);
   assign do_comp = acc && (req_op == OP_COMPUTE);
   // chain only runs when both strings hold symbols and neither overflowed
   assign start_run = do_comp && !a_ovf_ff && !b_ovf_ff
                      && (a_cnt_ff != '0) && (b_cnt_ff != '0);

   // ---------------- string loading ----------------
   always_ff @(posedge clock) begin
      if (app_a && (a_cnt_ff < FULL)) a_mem_ff[a_cnt_ff[IDX_W-1:0]] <= req_sym;
      if (reset || do_comp) begin
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
         a_ovf_ff <= 1'b0;
         b_ovf_ff <= 1'b0;
      end else begin
         if (app_a) begin
            if (a_cnt_ff < FULL) a_cnt_ff <= a_cnt_ff + CNT_W'(1);
            else a_ovf_ff <= 1'b1;
         end
         if (app_b) begin
            if (b_cnt_ff < FULL) b_cnt_ff <= b_cnt_ff + CNT_W'(1);
            else b_ovf_ff <= 1'b1;
         end
      end
   end

   // ---------------- row feed into the first cell ----------------
   assign a_sym = a_mem_ff[rd_ff[IDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (start_run) begin
         la_ff <= a_cnt_ff;
         lb_ff <= b_cnt_ff;
         rd_ff <= '0;
      end else if (feed_ff.valid || (state_ff == ST_RUN && rd_ff < la_ff)) begin
         if (rd_ff < la_ff) rd_ff <= rd_ff + CNT_W'(1);
      end
      feed_ff.valid <= (state_ff == ST_RUN) && (rd_ff < la_ff) && !reset;
      if ((state_ff == ST_RUN) && (rd_ff < la_ff)) begin
         feed_ff.first <= (rd_ff == '0);
         feed_ff.last  <= ((rd_ff + CNT_W'(1)) == la_ff);
         feed_ff.sym   <= a_sym;
         feed_ff.psym  <= prev_a_ff;
         feed_ff.val   <= DIST_W'(rd_ff) + DIST_W'(1);  // left edge score
         feed_ff.diag  <= DIST_W'(rd_ff);
         prev_a_ff     <= a_sym;
      end
   end

   ed_array #(
      .MAX_LEN (MAX_LEN),
      .CNT_W   (CNT_W)
   ) u_array (
      .clock    (clock),
      .reset    (reset),
      .tr_en    (tr_en_ff),
      .init     (start_run),
      .load_en  (app_b && (b_cnt_ff < FULL)),
      .load_idx (b_cnt_ff),
      .load_sym (req_sym),
      .sel_len  (lb_ff),
      .feed     (feed_ff),
      .done     (done),
      .done_val (done_val)
   );

   // ---------------- control ----------------
   // result moves to the output register once that slot is free
   assign rsp_load = (state_ff == ST_WAIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_run) state_in = ST_RUN;
            else if (do_comp) state_in = ST_WAIT;
         end
         ST_RUN: begin
            if (done) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (do_comp) begin
         // overflow and empty-string answers skip the chain
         if (a_ovf_ff || b_ovf_ff) res_ff <= OVERFLOW_DISTANCE;
         else res_ff <= DIST_W'(a_cnt_ff) + DIST_W'(b_cnt_ff);
      end else if ((state_ff == ST_RUN) && done) begin
         res_ff <= done_val;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= res_ff;
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

FILE: tb/tb_edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edit_distance_engine
// self-checking bench for the restricted damerau-levenshtein engine
// ----------------------------------------------------------------------------
// Strings are loaded one symbol per item on the req stream and a compute item
// asks for their distance. A local predictor keeps its own copy of both
// strings, their overflow flags and the transposition switch, and queues the
// expected distance whenever a compute is accepted. Results on the rsp stream
// are checked in order against that queue. A short table of hand-picked items
// runs first, then random string pairs over several register settings, with
// random gaps on both streams, a long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine;
   import ed_pkg::*;

   localparam int MAX_LEN        = 32;
   localparam int RANDOM_ITEMS   = 1430;
   localparam int PHASES         = 6;
   localparam int SETTLE_CYCLES  = 100;   // longer than the longest compute
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PREDICTED      = -1;    // table row with no typed distance
   localparam int DIR_N          = 21;

   // the one operation code the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] CSR_TRANSPOSITION_ADDR = {REG_TRANSPOSITION, 2'b00};

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] sym;
      int               known;
   } stim_row_type;

   // transposition is on after reset
   stim_row_type directed [DIR_N] = '{
      '{OP_COMPUTE,       8'h00, 0},          // both strings empty
      '{OP_APPEND_FIRST,  8'h00, PREDICTED},
      '{OP_COMPUTE,       8'hff, 1},          // second string empty
      '{OP_APPEND_SECOND, 8'hff, PREDICTED},
      '{OP_COMPUTE,       8'h00, 1},          // first string empty
      '{OP_APPEND_FIRST,  8'hff, PREDICTED},
      '{OP_APPEND_SECOND, 8'hff, PREDICTED},
      '{OP_COMPUTE,       8'h00, 0},          // equal strings
      '{OP_APPEND_FIRST,  8'h61, PREDICTED},
      '{OP_APPEND_FIRST,  8'h62, PREDICTED},
      '{OP_APPEND_SECOND, 8'h62, PREDICTED},
      '{OP_APPEND_SECOND, 8'h61, PREDICTED},
      '{OP_COMPUTE,       8'h00, 1},          // one adjacent swap
      '{OP_UNUSED,        8'haa, PREDICTED},  // ignored code
      '{OP_UNUSED,        8'h55, PREDICTED},
      '{OP_COMPUTE,       8'h00, 0},          // ignored items left no symbols
      '{OP_APPEND_FIRST,  8'h55, PREDICTED},
      '{OP_APPEND_FIRST,  8'haa, PREDICTED},
      '{OP_APPEND_SECOND, 8'h00, PREDICTED},
      '{OP_APPEND_SECOND, 8'h80, PREDICTED},
      '{OP_COMPUTE,       8'h00, PREDICTED}
   };

   // register words per random phase; bit 0 is the switch, the rest is noise
   logic [31:0] swap_words [PHASES] = '{
      32'h0000_0000, 32'hffff_ffff, 32'hffff_fffe,
      32'h0000_0001, 32'h0000_0000, 32'h0000_0001
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [1:0] operation, [9:2] symbol, [15:10] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [6:0] distance, [7] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [SYM_W-1:0] first_str  [MAX_LEN];
   logic [SYM_W-1:0] second_str [MAX_LEN];
   int               first_len  = 0;
   int               second_len = 0;
   bit               first_ovf  = 1'b0;
   bit               second_ovf = 1'b0;
   bit               swap_en    = 1'b1;

   logic [DIST_W-1:0] distance_queue [$];
   int                fail_count  = 0;
   int                items_sent  = 0;
   int                idle_cycles = 0;
   bit                quiet       = 1'b0;  // no gaps on either stream
   bit                rsp_hold_req = 1'b0;

   edit_distance_engine #(.MAX_LEN(MAX_LEN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // optimal string alignment over the loaded strings, full table
   function automatic logic [DIST_W-1:0] osa_distance();
      int score [0:MAX_LEN][0:MAX_LEN];
      int best;
      int cost;
      for (int i = 0; i <= first_len; i++) score[i][0] = i;
      for (int j = 0; j <= second_len; j++) score[0][j] = j;
      for (int i = 1; i <= first_len; i++) begin
         for (int j = 1; j <= second_len; j++) begin
            cost = (first_str[i-1] == second_str[j-1]) ? 0 : 1;
            best = score[i-1][j] + 1;
            if (score[i][j-1] + 1 < best) best = score[i][j-1] + 1;
            if (score[i-1][j-1] + cost < best) best = score[i-1][j-1] + cost;
            // adjacent swap, counted only when the switch is on
            if (swap_en && i > 1 && j > 1 && first_str[i-1] == second_str[j-2] &&
                first_str[i-2] == second_str[j-1] && score[i-2][j-2] + 1 < best) begin
               best = score[i-2][j-2] + 1;
            end
            score[i][j] = best;
         end
      end
      return DIST_W'(score[first_len][second_len]);
   endfunction

   // advance the predictor by one accepted item; returns 1 when a result is due
   function automatic bit predict_item(input logic [OP_W-1:0] op,
                                       input logic [SYM_W-1:0] sym,
                                       output logic [DIST_W-1:0] want);
      want = '0;
      predict_item = 1'b0;
      case (op)
         OP_APPEND_FIRST: begin
            if (first_len < MAX_LEN) begin
               first_str[first_len] = sym;
               first_len++;
            end else begin
               first_ovf = 1'b1;          // symbol dropped on a full string
            end
         end
         OP_APPEND_SECOND: begin
            if (second_len < MAX_LEN) begin
               second_str[second_len] = sym;
               second_len++;
            end else begin
               second_ovf = 1'b1;
            end
         end
         OP_COMPUTE: begin
            want = (first_ovf || second_ovf) ? OVERFLOW_DISTANCE : osa_distance();
            first_len  = 0;
            second_len = 0;
            first_ovf  = 1'b0;
            second_ovf = 1'b0;
            predict_item = 1'b1;
         end
         default: ;                       // unused code leaves everything alone
      endcase
   endfunction

   task automatic note_failure(input string what, input int expected, input int actual);
      if (fail_count < 10)
         $display("mismatch at %0t: %s expected %0d got %0d", $time, what, expected, actual);
      fail_count++;
   endtask

   // offer one item after a random gap and wait for it to be taken;
   // valid stays high afterwards so a zero gap gives back-to-back items
   task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                            input int known);
      int gap;
      logic [DIST_W-1:0] want;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, sym, op};
      do @(posedge clock); while (!req_tready);
      if (predict_item(op, sym, want))
         distance_queue.push_back(known >= 0 ? DIST_W'(known) : want);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // sender stops until every queued distance has come back, then lets the
   // block settle in case an append is still being absorbed
   task automatic drain();
      req_tvalid <= 1'b0;
      while (distance_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the switch, then read it back
   task automatic set_transposition(input logic [31:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_TRANSPOSITION_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      swap_en = word[0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[0] !== swap_en) note_failure("transposition readback", swap_en,
                                                  csr_prdata[0]);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one random string pair: mostly short, some up to full length, a few past it
   task automatic run_sequence();
      logic [SYM_W-1:0] first_part [$];
      logic [SYM_W-1:0] second_part [$];
      logic [SYM_W-1:0] held;
      int len_a;
      int len_b;
      int pick;
      int base;
      int ia;
      int ib;
      int k;
      bit narrow;
      quiet  = ($urandom_range(0, 6) == 0);
      narrow = $urandom_range(0, 1);     // few distinct symbols, so many matches
      base   = $urandom_range(0, 255);
      pick   = $urandom_range(0, 99);
      len_a  = pick < 75 ? $urandom_range(0, 8) :
               pick < 93 ? $urandom_range(0, MAX_LEN) :
                           $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
      pick   = $urandom_range(0, 99);
      len_b  = pick < 75 ? $urandom_range(0, 8) :
               pick < 93 ? $urandom_range(0, MAX_LEN) :
                           $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
      for (k = 0; k < len_a; k++)
         first_part.push_back(narrow ? SYM_W'(base + $urandom_range(0, 3))
                                     : SYM_W'($urandom_range(0, 255)));
      if (narrow && $urandom_range(0, 2) == 0) begin
         // near copy of the first string: one swap and maybe one substitution
         second_part = first_part;
         if (second_part.size() > 1) begin
            k = $urandom_range(0, second_part.size() - 2);
            held = second_part[k];
            second_part[k] = second_part[k+1];
            second_part[k+1] = held;
            if ($urandom_range(0, 1))
               second_part[$urandom_range(0, second_part.size() - 1)] =
                  SYM_W'(base + $urandom_range(0, 3));
         end
      end else begin
         for (k = 0; k < len_b; k++)
            second_part.push_back(narrow ? SYM_W'(base + $urandom_range(0, 3))
                                         : SYM_W'($urandom_range(0, 255)));
      end
      ia = 0;
      ib = 0;
      // interleave the two strings, with an odd ignored item mixed in
      while (ia < first_part.size() || ib < second_part.size()) begin
         if ($urandom_range(0, 19) == 0)
            send_item(OP_UNUSED, SYM_W'($urandom_range(0, 255)), PREDICTED);
         if (ib == second_part.size() || (ia < first_part.size() && $urandom_range(0, 1))) begin
            send_item(OP_APPEND_FIRST, first_part[ia], PREDICTED);
            ia++;
         end else begin
            send_item(OP_APPEND_SECOND, second_part[ib], PREDICTED);
            ib++;
         end
      end
      // now and then no compute, so the strings carry into the next pair
      if ($urandom_range(0, 19) != 0)
         send_item(OP_COMPUTE, SYM_W'($urandom_range(0, 255)), PREDICTED);
   endtask

   // result checking against the oldest queued distance
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (distance_queue.size() == 0) begin
            note_failure("unexpected result, distance", -1, rsp_tdata[DIST_W-1:0]);
         end else begin
            if (rsp_tdata[DIST_W-1:0] !== distance_queue[0])
               note_failure("distance", distance_queue[0], rsp_tdata[DIST_W-1:0]);
            void'(distance_queue.pop_front());
         end
      end
   end

   // watchdog on cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls per item, with one long hold-off on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // stimulus
   initial begin
      int target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // hand-picked items with the switch at its reset value
      for (int r = 0; r < DIR_N; r++)
         send_item(directed[r].op, directed[r].sym, directed[r].known);
      drain();

      // random phases, each behind a full drain and a register write
      for (int p = 0; p < PHASES; p++) begin
         set_transposition(swap_words[p]);
         // second phase starts with the receiver stalled while items keep coming
         if (p == 1) rsp_hold_req = 1'b1;
         target = DIR_N + (p + 1) * RANDOM_ITEMS / PHASES;
         while (items_sent < target) run_sequence();
         drain();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/ed_pkg.sv
hdl/ed_cell.sv
hdl/ed_array.sv
hdl/edit_distance_engine.sv
tb/tb_edit_distance_engine.sv
